// ----- rtl/debug_watchpoint_slot_manager_unit_defines.svh -----
// assertion helpers shared by the watchpoint slot manager
`ifndef DEBUG_WATCHPOINT_SLOT_MANAGER_UNIT_DEFINES_SVH
`define DEBUG_WATCHPOINT_SLOT_MANAGER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DWSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DWSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dwsm_pkg.sv -----
package dwsm_pkg;

  localparam int unsigned SLOTS  = 4;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int unsigned KIND_BASE = 16;
  localparam int unsigned LEN_BASE  = 18;

  localparam logic [3:0] LEN_EIGHT      = 4'd8;
  localparam logic [1:0] LEN_CODE_EIGHT = 2'd2;

  typedef enum logic [2:0] {
    CMD_SET     = 3'd0,
    CMD_CLR_ONE = 3'd1,
    CMD_CLR_ALL = 3'd2,
    CMD_INSTALL = 3'd3,
    CMD_CHECK   = 3'd4
  } dwsm_cmd_e;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_ALREADY   = 3'd1;
  localparam logic [2:0] STS_FULL      = 3'd2;
  localparam logic [2:0] STS_INVALID   = 3'd3;
  localparam logic [2:0] STS_NOT_SET   = 3'd4;
  localparam logic [2:0] STS_ZERO_ADDR = 3'd5;

  localparam logic [2:0] REG_STATUS  = 3'd6;
  localparam logic [2:0] REG_CONTROL = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SET_ZERO,
    S_SET_SCAN,
    S_SET_FIND,
    S_CLR_ONE,
    S_LIVE_SCAN,
    S_CLR_ALL,
    S_INS_BUILD,
    S_INS_ADDR,
    S_INS_STAT,
    S_INS_CTRL,
    S_RESP
  } dwsm_state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] watch_address;
    logic [1:0]  access_kind;
    logic [3:0]  watch_length;
    logic [2:0]  slot_number;
    logic [63:0] debug_reg_in;
  } dwsm_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  slot_used;
    logic        hit;
    logic        reg_write;
    logic [2:0]  reg_index;
    logic [63:0] reg_value;
    logic [63:0] saved_control_out;
    logic        last;
  } dwsm_res_t;

  typedef struct packed {
    logic      valid;
    dwsm_res_t res;
  } dwsm_emit_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } dwsm_cmp_req_t;

  // length 8 maps to the 8-byte code, others to (len - 1) mod 4
  function automatic logic [1:0] len_code(input logic [3:0] len);
    logic [3:0] m1;
    m1 = len - 4'd1;
    if (len == LEN_EIGHT) begin
      return LEN_CODE_EIGHT;
    end
    return m1[1:0];
  endfunction

endpackage

// ----- rtl/dwsm_if.sv -----
interface dwsm_in_if import dwsm_pkg::*; ();
  logic      valid;
  logic      ready;
  dwsm_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dwsm_out_if import dwsm_pkg::*; ();
  logic      valid;
  logic      ready;
  dwsm_res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/debug_watchpoint_slot_manager_unit.sv -----
// Watchpoint slot manager: four slots of address, kind, length and a delete mark.
// in_i carries one command beat (set, clear one, clear all, install, check);
// out_o returns result beats, last marking the final beat of a command.
// Every command gives one beat, but an install with a slot active gives one address-register
// write per live slot, then a status write and a control write (up to six).
// One 64-bit comparator is shared by all scan steps, one slot per cycle while
// the receiver keeps up (the install write pass waits on it); steps per command:
//   set: zero check, duplicate scan, free-slot search
//   clear one: slot check, then a live-slot scan if in range; clear all: one pass
//   check, unknown commands and install with nothing active: the result beat only
//   install: build pass and write pass over all slots, then two writes
// in_i.ready is high only while no command is in progress; a new command is
// taken while the last result beat still sits in the output register.
// A stalled receiver holds the beat in the output register and the sequencer
// waits on it; nothing is dropped.
// Reset frees every slot, clears the active flag and the saved control word,
// and leaves the output channel empty.
`include "debug_watchpoint_slot_manager_unit_defines.svh"

module debug_watchpoint_slot_manager_unit import dwsm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  dwsm_in_if.sink           in_i,
  dwsm_out_if.source        out_o
);

  dwsm_cmp_req_t cmp_req;
  logic          cmp_eq;
  dwsm_emit_t    emit;
  logic          out_free;
  logic          out_valid_q;
  dwsm_res_t     out_q;

  assign out_free = !out_valid_q || out_o.ready;

  dwsm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_req_i   (in_i.payload),
    .in_ready_o (in_i.ready),
    .cmp_req_o  (cmp_req),
    .cmp_eq_i   (cmp_eq),
    .emit_o     (emit),
    .out_free_i (out_free)
  );

  dwsm_cmp u_cmp (
    .req_i (cmp_req),
    .eq_o  (cmp_eq)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_q <= emit.res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  `DWSM_ASSERT_NXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "ready after accept")
  `DWSM_ASSERT_IMP(a_no_overwrite, emit.valid, out_free, "result beat overwritten")
  `DWSM_ASSERT_IMP(a_saved_enabled, out_valid_q && (out_q.saved_control_out != 64'd0), out_q.saved_control_out[7:0] != 8'd0, "saved control without enable")
  `DWSM_ASSERT_IMP(a_idle_write_zero, out_valid_q && !out_q.reg_write, (out_q.reg_index == 3'd0) && (out_q.reg_value == 64'd0), "register fields set without write")

endmodule

// ----- rtl/dwsm_cmp.sv -----
module dwsm_cmp import dwsm_pkg::*; (
  input  dwsm_cmp_req_t req_i,
  output logic          eq_o
);

  // one 64-bit equality compare, shared by every scan step
  assign eq_o = (req_i.a == req_i.b);

endmodule

// ----- rtl/dwsm_seq.sv -----
module dwsm_seq import dwsm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  dwsm_req_t     in_req_i,
  output logic          in_ready_o,
  output dwsm_cmp_req_t cmp_req_o,
  input  logic          cmp_eq_i,
  output dwsm_emit_t    emit_o,
  input  logic          out_free_i
);

  dwsm_state_e       state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_nx, rd_idx;
  logic              idx_last;
  dwsm_req_t         req_q;

  logic [63:0]       slot_addr_q [SLOTS];
  logic [1:0]        slot_kind_q [SLOTS];
  logic [3:0]        slot_len_q  [SLOTS];
  logic [SLOTS-1:0]  del_q;
  logic [SLOTS-1:0]  live_q;
  logic              any_active_q;
  logic              found_q;
  logic [63:0]       saved_ctl_q;
  logic [63:0]       ctl_q, ctl_nx;
  logic [2:0]        sts_q;
  logic [1:0]        slot_q;
  logic              hit_q;

  logic              accept;
  logic              slot_ok;
  logic              cur_del;
  logic              cur_live;
  logic              chk_hit;
  logic [1:0]        chk_slot;
  logic [5:0]        en_pos, kind_pos, len_pos;

  assign accept   = in_valid_i && in_ready_o;
  assign idx_last = (idx_q == SLOT_W'(SLOTS - 1));
  assign idx_nx   = idx_last ? '0 : idx_q + 1'b1;
  assign slot_ok  = (req_q.slot_number < 3'(SLOTS));
  assign rd_idx   = (state_q == S_CLR_ONE) ? req_q.slot_number[SLOT_W-1:0] : idx_q;
  assign cur_del  = del_q[rd_idx];
  assign cur_live = !cmp_eq_i && !cur_del;

  // lowest set hit bit wins
  always_comb begin
    chk_hit  = |in_req_i.debug_reg_in[3:0];
    chk_slot = 2'd0;
    priority if (in_req_i.debug_reg_in[0]) chk_slot = 2'd0;
    else if (in_req_i.debug_reg_in[1])     chk_slot = 2'd1;
    else if (in_req_i.debug_reg_in[2])     chk_slot = 2'd2;
    else if (in_req_i.debug_reg_in[3])     chk_slot = 2'd3;
    else                                   chk_slot = 2'd0;
  end

  // control word update for the slot under the scan pointer
  always_comb begin
    en_pos   = 6'({idx_q, 1'b1});
    kind_pos = 6'(KIND_BASE) + 6'({idx_q, 2'b00});
    len_pos  = 6'(LEN_BASE) + 6'({idx_q, 2'b00});
    ctl_nx   = ctl_q;
    if (cur_del) begin
      ctl_nx[en_pos] = 1'b0;
    end else if (!cmp_eq_i) begin
      ctl_nx[en_pos]        = 1'b1;
      ctl_nx[len_pos +: 2]  = len_code(slot_len_q[rd_idx]);
      ctl_nx[kind_pos +: 2] = slot_kind_q[rd_idx];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req_i.command)
            CMD_SET:     state_d = S_SET_ZERO;
            CMD_CLR_ONE: state_d = S_CLR_ONE;
            CMD_CLR_ALL: state_d = S_CLR_ALL;
            CMD_INSTALL: state_d = any_active_q ? S_INS_BUILD : S_RESP;
            default:     state_d = S_RESP;
          endcase
        end
      end
      S_SET_ZERO:  state_d = cmp_eq_i ? S_RESP : S_SET_SCAN;
      S_SET_SCAN: begin
        if (cmp_eq_i && !cur_del) state_d = S_RESP;
        else if (idx_last)        state_d = S_SET_FIND;
      end
      S_SET_FIND:  if (cmp_eq_i || idx_last) state_d = S_RESP;
      S_CLR_ONE:   state_d = slot_ok ? S_LIVE_SCAN : S_RESP;
      S_LIVE_SCAN: if (idx_last) state_d = S_RESP;
      S_CLR_ALL:   if (idx_last) state_d = S_RESP;
      S_INS_BUILD: if (idx_last) state_d = S_INS_ADDR;
      S_INS_ADDR:  if (idx_last && (!live_q[idx_q] || out_free_i)) state_d = S_INS_STAT;
      S_INS_STAT:  if (out_free_i) state_d = S_INS_CTRL;
      S_INS_CTRL:  if (out_free_i) state_d = S_IDLE;
      S_RESP:      if (out_free_i) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    cmp_req_o.a = slot_addr_q[rd_idx];
    cmp_req_o.b = '0;
    emit_o.valid                 = 1'b0;
    emit_o.res.status            = sts_q;
    emit_o.res.slot_used         = slot_q;
    emit_o.res.hit               = hit_q;
    emit_o.res.reg_write         = 1'b0;
    emit_o.res.reg_index         = '0;
    emit_o.res.reg_value         = '0;
    emit_o.res.saved_control_out = saved_ctl_q;
    emit_o.res.last              = 1'b1;
    unique case (state_q)
      S_SET_ZERO: cmp_req_o.a = req_q.watch_address;
      S_SET_SCAN: cmp_req_o.b = req_q.watch_address;
      S_INS_ADDR: begin
        emit_o.valid         = live_q[idx_q] && out_free_i;
        emit_o.res.status    = STS_OK;
        emit_o.res.slot_used = '0;
        emit_o.res.hit       = 1'b0;
        emit_o.res.reg_write = 1'b1;
        emit_o.res.reg_index = 3'(idx_q);
        emit_o.res.reg_value = slot_addr_q[rd_idx];
        emit_o.res.last      = 1'b0;
      end
      S_INS_STAT: begin
        emit_o.valid         = out_free_i;
        emit_o.res.status    = STS_OK;
        emit_o.res.slot_used = '0;
        emit_o.res.hit       = 1'b0;
        emit_o.res.reg_write = 1'b1;
        emit_o.res.reg_index = REG_STATUS;
        emit_o.res.last      = 1'b0;
      end
      S_INS_CTRL: begin
        emit_o.valid         = out_free_i;
        emit_o.res.status    = STS_OK;
        emit_o.res.slot_used = '0;
        emit_o.res.hit       = 1'b0;
        emit_o.res.reg_write = 1'b1;
        emit_o.res.reg_index = REG_CONTROL;
        emit_o.res.reg_value = ctl_q;
      end
      S_RESP:  emit_o.valid = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      del_q        <= '0;
      any_active_q <= 1'b0;
      found_q      <= 1'b0;
      saved_ctl_q  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_addr_q[i] <= '0;
        slot_kind_q[i] <= '0;
        slot_len_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q   <= '0;
            found_q <= 1'b0;
          end
        end
        S_SET_SCAN: begin
          if (!(cmp_eq_i && !cur_del)) begin
            // reclaim a slot pending delete
            if (cur_del) begin
              slot_addr_q[rd_idx] <= '0;
              slot_kind_q[rd_idx] <= '0;
              slot_len_q[rd_idx]  <= '0;
              del_q[rd_idx]       <= 1'b0;
            end
            idx_q <= idx_nx;
          end
        end
        S_SET_FIND: begin
          if (cmp_eq_i) begin
            slot_addr_q[rd_idx] <= req_q.watch_address;
            slot_kind_q[rd_idx] <= req_q.access_kind;
            slot_len_q[rd_idx]  <= req_q.watch_length;
            any_active_q        <= 1'b1;
          end else begin
            idx_q <= idx_nx;
          end
        end
        S_CLR_ONE: begin
          if (slot_ok && !cmp_eq_i) del_q[rd_idx] <= 1'b1;
          idx_q   <= '0;
          found_q <= 1'b0;
        end
        S_LIVE_SCAN: begin
          found_q <= found_q || cur_live;
          idx_q   <= idx_nx;
          if (idx_last && !(found_q || cur_live)) any_active_q <= 1'b0;
        end
        S_CLR_ALL: begin
          if (!cmp_eq_i) del_q[rd_idx] <= 1'b1;
          idx_q <= idx_nx;
          if (idx_last) any_active_q <= 1'b0;
        end
        S_INS_BUILD: begin
          idx_q <= idx_nx;
          if (idx_last) saved_ctl_q <= (ctl_nx[7:0] != 8'd0) ? ctl_nx : '0;
        end
        S_INS_ADDR: begin
          if (!live_q[idx_q] || out_free_i) idx_q <= idx_nx;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_q  <= in_req_i;
          ctl_q  <= in_req_i.debug_reg_in;
          sts_q  <= STS_OK;
          slot_q <= (in_req_i.command == CMD_CHECK) ? chk_slot : 2'd0;
          hit_q  <= (in_req_i.command == CMD_CHECK) && chk_hit;
        end
      end
      S_SET_ZERO: if (cmp_eq_i) sts_q <= STS_ZERO_ADDR;
      S_SET_SCAN: if (cmp_eq_i && !cur_del) sts_q <= STS_ALREADY;
      S_SET_FIND: begin
        if (cmp_eq_i)      slot_q <= 2'(idx_q);
        else if (idx_last) sts_q  <= STS_FULL;
      end
      S_CLR_ONE: begin
        if (!slot_ok)      sts_q <= STS_INVALID;
        else if (cmp_eq_i) sts_q <= STS_NOT_SET;
        else               sts_q <= STS_OK;
      end
      S_INS_BUILD: begin
        ctl_q          <= ctl_nx;
        live_q[rd_idx] <= cur_live;
      end
      default: ;
    endcase
  end

endmodule
